FILE: hdl/sequenced_feed_arbiter_macros.svh
// assertion macros used by the checker of the feed arbiter
// depends on nothing; included by the checker module
`ifndef SEQUENCED_FEED_ARBITER_MACROS_SVH
`define SEQUENCED_FEED_ARBITER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SFA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sequenced_feed_arbiter assertion failed");

// next-cycle implication, disabled while reset is held
`define SFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sequenced_feed_arbiter assertion failed");

`endif

FILE: hdl/sfa_pkg.sv
// shared constants, codes and types of the sequenced feed arbiter
// no dependencies; imported by every module of the block
package sfa_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int TAG_BITS    = 32;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam int CAP_W  = 6;
    localparam int SEQ_W  = 64;
    localparam int TAG_W  = 32;
    localparam int CNT_W  = 32;
    localparam int ACC_W  = 6;

    localparam logic [TAG_W-1:0] TAG_MASK = (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} :
        TAG_W'((64'd1 << TAG_BITS) - 64'd1);

    // result kinds
    localparam logic [1:0] KIND_REL  = 2'd0;
    localparam logic [1:0] KIND_REQ  = 2'd1;
    localparam logic [1:0] KIND_OVF  = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_START_KNOWN = 2'd0;
    localparam logic [1:0] CFG_START_SEQ   = 2'd1;
    localparam logic [1:0] CFG_CAP_LIMIT   = 2'd2;

    // stream word widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 232;

    // table update request from the sequencer
    typedef struct packed {
        logic             wr_en;
        logic             clr_en;
        logic [SEQ_W-1:0] seq;
        logic             side;
        logic [TAG_W-1:0] tag;
    } tbl_ctrl_t;

    // shared comparator result
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

FILE: hdl/sequenced_feed_arbiter.sv
// top level of the A/B feed arbiter: sequencer, config registers, result register
// depends on sfa_pkg, sfa_cmp and sfa_table
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    s_tdata, s_tuser, s_tlast
//  m_        out        m_tvalid/m_tready    m_tdata, m_tuser, m_tlast
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a message word passes the accept, check, place and after steps, with a duplicate scan
// of the table before place when the table is not empty (a stale or duplicate word skips
// place); a packet end adds a drain step, then per released word a find scan of the table
// and a release step, then a failed find scan and a minimum scan, a request step and the
// done word. with an empty table the drain goes straight to the done word.
// reset is synchronous, active low; the table comes out empty with no pass.
// a stalled m_ side holds the sequencer at the next result; s_tready is low meanwhile.
module sequenced_feed_arbiter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // msg_sequence[63:0], feed_side[64], payload_tag[96:65], zero fill
    input  logic [sfa_pkg::S_TDATA_W-1:0]   s_tdata,
    // has_message[0]
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // first_seq[63:0], last_seq[127:64], out_side[128], out_tag[160:129],
    // accepted_count[166:161], duplicate_total[198:167],
    // request_total[230:199], zero fill
    output logic [sfa_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind[1:0]
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [sfa_pkg::SEQ_W-1:0]       cfg_data
);
    import sfa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DUPSCAN, S_PLACE, S_AFTER,
        S_DRAIN, S_FIND, S_REL, S_MIN, S_REQ, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SEQ_W-1:0]  in_seq_reg, in_seq_next;
    logic              in_side_reg, in_side_next;
    logic [TAG_W-1:0]  in_tag_reg, in_tag_next;
    logic              in_has_reg, in_has_next;
    logic              in_end_reg, in_end_next;
    logic              exp_valid_reg, exp_valid_next;
    logic [SEQ_W-1:0]  exp_seq_reg, exp_seq_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SEQ_W-1:0]  pend_first_reg, pend_first_next;
    logic [SEQ_W-1:0]  pend_last_reg, pend_last_next;
    logic [ACC_W-1:0]  pkt_acc_reg, pkt_acc_next;
    logic [CNT_W-1:0]  dup_cnt_reg, dup_cnt_next;
    logic [CNT_W-1:0]  req_cnt_reg, req_cnt_next;
    logic [SEQ_W-1:0]  low_reg, low_next;
    logic              any_reg, any_next;
    logic              start_known_reg;
    logic [SEQ_W-1:0]  start_seq_reg;
    logic [CAP_W-1:0]  cap_limit_reg;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic [SEQ_W-1:0]  out_first_reg, out_first_next;
    logic [SEQ_W-1:0]  out_last_reg, out_last_next;
    logic              out_side_reg, out_side_next;
    logic [TAG_W-1:0]  out_tag_reg, out_tag_next;
    logic [ACC_W-1:0]  out_acc_reg, out_acc_next;
    logic [CNT_W-1:0]  out_dup_reg, out_dup_next;
    logic [CNT_W-1:0]  out_req_reg, out_req_next;
    logic              out_tlast_reg, out_tlast_next;

    tbl_ctrl_t         tbl_ctrl;
    logic              rd_valid;
    logic [SEQ_W-1:0]  rd_seq;
    logic              rd_side;
    logic [TAG_W-1:0]  rd_tag;
    logic [USED_W-1:0] used;
    logic [SEQ_W-1:0]  cmp_a, cmp_b;
    cmp_res_t          cmp;
    logic [CAP_W-1:0]  cap_eff;
    logic              out_free;
    logic              idx_last;
    logic [SEQ_W-1:0]  low_m1;
    logic [CNT_W-1:0]  req_inc;

    sfa_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (idx_reg),
        .ctrl     (tbl_ctrl),
        .rd_valid (rd_valid),
        .rd_seq   (rd_seq),
        .rd_side  (rd_side),
        .rd_tag   (rd_tag),
        .used     (used)
    );

    sfa_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp)
    );

    // operand selection for the shared comparator
    always_comb begin
        unique case (state_reg)
            S_CHECK: begin
                cmp_a = in_seq_reg;
                cmp_b = exp_seq_reg;
            end
            S_DUPSCAN: begin
                cmp_a = rd_seq;
                cmp_b = in_seq_reg;
            end
            S_MIN: begin
                cmp_a = rd_seq;
                cmp_b = low_reg;
            end
            S_REQ: begin
                cmp_a = exp_seq_reg;
                cmp_b = low_reg;
            end
            default: begin
                cmp_a = rd_seq;
                cmp_b = exp_seq_reg;
            end
        endcase
    end

    assign cap_eff  = (cap_limit_reg == '0) ? CAP_W'(1) :
                      (cap_limit_reg > CAP_W'(TABLE_DEPTH)) ? CAP_W'(TABLE_DEPTH) :
                      cap_limit_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign idx_last = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign low_m1   = low_reg - SEQ_W'(1);
    assign req_inc  = (req_cnt_reg == {CNT_W{1'b1}}) ? req_cnt_reg : req_cnt_reg + CNT_W'(1);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        in_seq_next     = in_seq_reg;
        in_side_next    = in_side_reg;
        in_tag_next     = in_tag_reg;
        in_has_next     = in_has_reg;
        in_end_next     = in_end_reg;
        exp_valid_next  = exp_valid_reg;
        exp_seq_next    = exp_seq_reg;
        pend_valid_next = pend_valid_reg;
        pend_first_next = pend_first_reg;
        pend_last_next  = pend_last_reg;
        pkt_acc_next    = pkt_acc_reg;
        dup_cnt_next    = dup_cnt_reg;
        req_cnt_next    = req_cnt_reg;
        low_next        = low_reg;
        any_next        = any_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;
        out_side_next   = out_side_reg;
        out_tag_next    = out_tag_reg;
        out_acc_next    = out_acc_reg;
        out_dup_next    = out_dup_reg;
        out_req_next    = out_req_reg;
        out_tlast_next  = out_tlast_reg;

        tbl_ctrl        = '0;
        tbl_ctrl.seq    = in_seq_reg;
        tbl_ctrl.side   = in_side_reg;
        tbl_ctrl.tag    = in_tag_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    in_seq_next  = s_tdata[63:0];
                    in_side_next = s_tdata[64];
                    in_tag_next  = s_tdata[96:65] & TAG_MASK;
                    in_has_next  = s_tuser;
                    in_end_next  = s_tlast || !s_tuser;
                    if (!exp_valid_reg) begin
                        exp_valid_next = 1'b1;
                        exp_seq_next   = start_known_reg ? start_seq_reg : s_tdata[63:0];
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                idx_next = '0;
                priority if (!in_has_reg) begin
                    state_next = S_DRAIN;
                end else if (cmp.lt) begin
                    if (dup_cnt_reg != {CNT_W{1'b1}}) dup_cnt_next = dup_cnt_reg + CNT_W'(1);
                    state_next = S_AFTER;
                end else if (used == '0) begin
                    state_next = S_PLACE;
                end else begin
                    state_next = S_DUPSCAN;
                end
            end
            S_DUPSCAN: begin
                priority if (rd_valid && cmp.eq) begin
                    if (dup_cnt_reg != {CNT_W{1'b1}}) dup_cnt_next = dup_cnt_reg + CNT_W'(1);
                    state_next = S_AFTER;
                end else if (idx_last) begin
                    state_next = S_PLACE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_PLACE: begin
                if (CAP_W'(used) >= cap_eff) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_OVF;
                        out_first_next = in_seq_reg;
                        out_last_next  = '0;
                        out_side_next  = 1'b0;
                        out_tag_next   = '0;
                        out_acc_next   = '0;
                        out_dup_next   = dup_cnt_reg;
                        out_req_next   = req_cnt_reg;
                        out_tlast_next = !in_end_reg;
                        state_next     = S_AFTER;
                    end
                end else begin
                    tbl_ctrl.wr_en = 1'b1;
                    if (pkt_acc_reg != {ACC_W{1'b1}}) pkt_acc_next = pkt_acc_reg + ACC_W'(1);
                    state_next = S_AFTER;
                end
            end
            S_AFTER: begin
                idx_next   = '0;
                state_next = in_end_reg ? S_DRAIN : S_IDLE;
            end
            S_DRAIN: begin
                idx_next   = '0;
                any_next   = 1'b0;
                state_next = (used == '0) ? S_DONE : S_FIND;
            end
            S_FIND: begin
                priority if (rd_valid && cmp.eq) begin
                    state_next = S_REL;
                end else if (idx_last) begin
                    idx_next   = '0;
                    state_next = S_MIN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_REL: begin
                // idx still points at the hit slot
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_REL;
                    out_first_next  = rd_seq;
                    out_last_next   = '0;
                    out_side_next   = rd_side;
                    out_tag_next    = rd_tag;
                    out_acc_next    = '0;
                    out_dup_next    = dup_cnt_reg;
                    out_req_next    = req_cnt_reg;
                    out_tlast_next  = 1'b0;
                    tbl_ctrl.clr_en = 1'b1;
                    exp_seq_next    = exp_seq_reg + SEQ_W'(1);
                    pend_valid_next = 1'b0;
                    state_next      = S_DRAIN;
                end
            end
            S_MIN: begin
                if (rd_valid && (!any_reg || cmp.lt)) begin
                    low_next = rd_seq;
                    any_next = 1'b1;
                end
                if (idx_last) begin
                    state_next = S_REQ;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_REQ: begin
                if (any_reg && cmp.lt && (!pend_valid_reg || pend_first_reg != exp_seq_reg
                                          || pend_last_reg != low_m1)) begin
                    if (out_free) begin
                        pend_valid_next = 1'b1;
                        pend_first_next = exp_seq_reg;
                        pend_last_next  = low_m1;
                        req_cnt_next    = req_inc;
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_REQ;
                        out_first_next  = exp_seq_reg;
                        out_last_next   = low_m1;
                        out_side_next   = 1'b0;
                        out_tag_next    = '0;
                        out_acc_next    = '0;
                        out_dup_next    = dup_cnt_reg;
                        out_req_next    = req_inc;
                        out_tlast_next  = 1'b0;
                        state_next      = S_DONE;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DONE;
                    out_first_next = exp_seq_reg;
                    out_last_next  = '0;
                    out_side_next  = 1'b0;
                    out_tag_next   = '0;
                    out_acc_next   = pkt_acc_reg;
                    out_dup_next   = dup_cnt_reg;
                    out_req_next   = req_cnt_reg;
                    out_tlast_next = 1'b1;
                    pkt_acc_next   = '0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            exp_valid_reg   <= 1'b0;
            exp_seq_reg     <= '0;
            pend_valid_reg  <= 1'b0;
            pend_first_reg  <= '0;
            pend_last_reg   <= '0;
            pkt_acc_reg     <= '0;
            dup_cnt_reg     <= '0;
            req_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            start_known_reg <= 1'b0;
            start_seq_reg   <= '0;
            cap_limit_reg   <= CAP_W'(TABLE_DEPTH);
        end else begin
            state_reg      <= state_next;
            exp_valid_reg  <= exp_valid_next;
            exp_seq_reg    <= exp_seq_next;
            pend_valid_reg <= pend_valid_next;
            pend_first_reg <= pend_first_next;
            pend_last_reg  <= pend_last_next;
            pkt_acc_reg    <= pkt_acc_next;
            dup_cnt_reg    <= dup_cnt_next;
            req_cnt_reg    <= req_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_START_KNOWN: start_known_reg <= cfg_data[0];
                    CFG_START_SEQ:   start_seq_reg   <= cfg_data;
                    CFG_CAP_LIMIT:   cap_limit_reg   <= cfg_data[CAP_W-1:0];
                    default:         ;
                endcase
            end
        end
        // datapath registers, no reset needed
        idx_reg       <= idx_next;
        in_seq_reg    <= in_seq_next;
        in_side_reg   <= in_side_next;
        in_tag_reg    <= in_tag_next;
        in_has_reg    <= in_has_next;
        in_end_reg    <= in_end_next;
        low_reg       <= low_next;
        any_reg       <= any_next;
        out_kind_reg  <= out_kind_next;
        out_first_reg <= out_first_next;
        out_last_reg  <= out_last_next;
        out_side_reg  <= out_side_next;
        out_tag_reg   <= out_tag_next;
        out_acc_reg   <= out_acc_next;
        out_dup_reg   <= out_dup_next;
        out_req_reg   <= out_req_next;
        out_tlast_reg <= out_tlast_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_kind_reg;
    assign m_tlast   = out_tlast_reg;
    assign m_tdata   = {1'b0, out_req_reg, out_dup_reg, out_acc_reg, out_tag_reg,
                        out_side_reg, out_last_reg, out_first_reg};

endmodule

FILE: hdl/sfa_cmp.sv
// shared 64-bit comparator of the sequencer: equality and unsigned less-than
// depends on sfa_pkg
module sfa_cmp (
    input  logic [sfa_pkg::SEQ_W-1:0] a,
    input  logic [sfa_pkg::SEQ_W-1:0] b,
    output sfa_pkg::cmp_res_t         res
);
    import sfa_pkg::*;

    assign res.eq = (a == b);
    assign res.lt = (a < b);

endmodule

FILE: hdl/sfa_table.sv
// reorder table: per-slot valid bits, sequence, side and tag stores, fill count
// depends on sfa_pkg; written and read by the sequencer in the top level
module sfa_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [sfa_pkg::IDX_W-1:0]     rd_idx,
    input  sfa_pkg::tbl_ctrl_t            ctrl,
    output logic                          rd_valid,
    output logic [sfa_pkg::SEQ_W-1:0]     rd_seq,
    output logic                          rd_side,
    output logic [sfa_pkg::TAG_W-1:0]     rd_tag,
    output logic [sfa_pkg::USED_W-1:0]    used
);
    import sfa_pkg::*;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [SEQ_W-1:0]       seq_reg  [TABLE_DEPTH];
    logic                   side_reg [TABLE_DEPTH];
    logic [TAG_W-1:0]       tag_reg  [TABLE_DEPTH];
    logic [USED_W-1:0]      used_reg;
    logic [IDX_W-1:0]       free_idx;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            used_reg  <= '0;
        end else if (ctrl.wr_en) begin
            valid_reg[free_idx] <= 1'b1;
            used_reg            <= used_reg + USED_W'(1);
        end else if (ctrl.clr_en) begin
            valid_reg[rd_idx] <= 1'b0;
            used_reg          <= used_reg - USED_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            seq_reg[free_idx]  <= ctrl.seq;
            side_reg[free_idx] <= ctrl.side;
            tag_reg[free_idx]  <= ctrl.tag;
        end
    end

    assign rd_valid = valid_reg[rd_idx];
    assign rd_seq   = seq_reg[rd_idx];
    assign rd_side  = side_reg[rd_idx];
    assign rd_tag   = tag_reg[rd_idx];
    assign used     = used_reg;

endmodule

FILE: hdl/sfa_checker.sv
// port-level checker for the sequenced feed arbiter, bound to the top level
// depends on sfa_pkg and sequenced_feed_arbiter_macros.svh
`include "sequenced_feed_arbiter_macros.svh"

module sfa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [sfa_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sfa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser,
    input logic                          m_tlast,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [1:0]                    cfg_index,
    input logic [sfa_pkg::SEQ_W-1:0]     cfg_data
);
    import sfa_pkg::*;

    // a stalled result word stays offered
    `SFA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // each packet closes with done, and done always ends the run
    `SFA_ASSERT_NOW(a_done_last, aclk, aresetn, m_tvalid && m_tuser == KIND_DONE, m_tlast)

    // a released message is never the final word of a run
    `SFA_ASSERT_NOW(a_rel_not_last, aclk, aresetn, m_tvalid && m_tuser == KIND_REL, !m_tlast)

    // the block works on one word at a time
    `SFA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a recovery range is never empty
    `SFA_ASSERT_NOW(a_req_range, aclk, aresetn, m_tvalid && m_tuser == KIND_REQ,
                    m_tdata[127:64] >= m_tdata[63:0])

endmodule

bind sequenced_feed_arbiter sfa_checker u_sfa_checker (.*);
